### design/longest_common_substring_macros.svh
// Assertion macros shared by the longest common substring design.
// Uses the clk and rst signals of the module that includes this header.
`ifndef LONGEST_COMMON_SUBSTRING_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LCS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lcs_pkg.sv
// Shared types, codes and width helpers for the longest common substring design.
// No dependencies.
package lcs_pkg;

  localparam int unsigned MAX_LEN_DEF = 32;

  typedef enum logic [1:0] {
    ACT_FIRST   = 2'd0,
    ACT_SECOND  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_FLUSH,
    ST_EMIT,
    ST_TAIL
  } state_t;

  // Controls from the sequencer to the string stores.
  typedef struct packed {
    logic append_first;
    logic append_second;
    logic clear;
  } str_ctl_t;

  // Controls from the sequencer to the suffix table.
  typedef struct packed {
    logic issue;
    logic clear_best;
    logic first_row;
    logic first_col;
  } cell_ctl_t;

  // Bits needed to address a store of the given depth.
  function automatic int unsigned idx_bits(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Bits needed to hold a count from zero up to the depth itself.
  function automatic int unsigned cnt_bits(int unsigned depth);
    return $clog2(depth + 1);
  endfunction

endpackage

### design/lcs_strings.sv
// Storage for the two strings: byte memories with registered reads, fill counts
// and the overflow flag. Depends on lcs_pkg.
module lcs_strings #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lcs_pkg::str_ctl_t                      ctl,
  input  logic [7:0]                             symbol,
  input  logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  a_addr,
  input  logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  b_addr,
  output logic [7:0]                             a_data,
  output logic [7:0]                             b_data,
  output logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  a_count,
  output logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  b_count,
  output logic                                   overflow
);
  import lcs_pkg::*;

  localparam int unsigned IW = idx_bits(MAX_LEN);
  localparam int unsigned CW = cnt_bits(MAX_LEN);

  logic [7:0] first_mem  [MAX_LEN];
  logic [7:0] second_mem [MAX_LEN];
  logic       a_full;
  logic       b_full;

  assign a_full = (a_count == CW'(MAX_LEN));
  assign b_full = (b_count == CW'(MAX_LEN));

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (ctl.append_first && !a_full) begin
      first_mem[a_count[IW-1:0]] <= symbol;
    end
    if (ctl.append_second && !b_full) begin
      second_mem[b_count[IW-1:0]] <= symbol;
    end
    a_data <= first_mem[a_addr];
    b_data <= second_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count  <= '0;
      b_count  <= '0;
      overflow <= 1'b0;
    end else if (ctl.clear) begin
      a_count  <= '0;
      b_count  <= '0;
      overflow <= 1'b0;
    end else begin
      if (ctl.append_first) begin
        if (a_full) begin
          overflow <= 1'b1;
        end else begin
          a_count <= a_count + CW'(1);
        end
      end
      if (ctl.append_second) begin
        if (b_full) begin
          overflow <= 1'b1;
        end else begin
          b_count <= b_count + CW'(1);
        end
      end
    end
  end

endmodule

### design/lcs_table.sv
// Common-suffix table: one row held in a memory, updated by read-modify-write,
// plus tracking of the longest run. Depends on lcs_pkg.
module lcs_table #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lcs_pkg::cell_ctl_t                     ctl,
  input  logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  row,
  input  logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  col,
  input  logic [7:0]                             a_data,
  input  logic [7:0]                             b_data,
  output logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  best_len,
  output logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  best_end
);
  import lcs_pkg::*;

  localparam int unsigned IW = idx_bits(MAX_LEN);
  localparam int unsigned CW = cnt_bits(MAX_LEN);

  logic [CW-1:0] suffix_mem [MAX_LEN];
  logic [CW-1:0] above_rd;
  logic          s1_valid;
  logic          s1_first_row;
  logic          s1_first_col;
  logic [IW-1:0] s1_row;
  logic [IW-1:0] s1_col;
  logic [CW-1:0] diag;
  logic          fwd;
  logic [CW-1:0] fwd_data;
  logic [CW-1:0] above;
  logic [CW-1:0] diag_in;
  logic [CW-1:0] run_len;

  // The previous row does not exist on the first row, so it reads as zero;
  // a write to the same column in the previous cycle is forwarded.
  always_comb begin
    above   = s1_first_row ? '0 : (fwd ? fwd_data : above_rd);
    diag_in = s1_first_col ? '0 : diag;
    run_len = (a_data == b_data) ? diag_in + CW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      suffix_mem[s1_col] <= run_len;
    end
    above_rd <= suffix_mem[col];
  end

  always_ff @(posedge clk) begin
    s1_first_row <= ctl.first_row;
    s1_first_col <= ctl.first_col;
    s1_row       <= row;
    s1_col       <= col;
    fwd          <= s1_valid && ctl.issue && (s1_col == col);
    fwd_data     <= run_len;
    if (s1_valid) begin
      diag <= above;
    end
  end

  // Only a strictly longer run replaces the best, so ties keep the first.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      best_len <= '0;
      best_end <= '0;
    end else begin
      s1_valid <= ctl.issue;
      if (ctl.clear_best) begin
        best_len <= '0;
        best_end <= '0;
      end else if (s1_valid && (run_len > best_len)) begin
        best_len <= run_len;
        best_end <= s1_row;
      end
    end
  end

endmodule

### design/lcs_ctrl.sv
// Sequencer: accepts requests, walks the table cell by cell, then reads the
// substring back and marks each result. Depends on lcs_pkg and the macros header.
`include "longest_common_substring_macros.svh"

module lcs_ctrl #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [1:0]                             action,
  input  logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  a_count,
  input  logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  b_count,
  input  logic [lcs_pkg::cnt_bits(MAX_LEN)-1:0]  best_len,
  input  logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  best_end,
  output logic                                   busy,
  output lcs_pkg::str_ctl_t                      str_ctl,
  output lcs_pkg::cell_ctl_t                     cell_ctl,
  output logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  row,
  output logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  col,
  output logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  a_addr,
  output logic [lcs_pkg::idx_bits(MAX_LEN)-1:0]  start_pos,
  output logic                                   strobe,
  output logic                                   last
);
  import lcs_pkg::*;

  localparam int unsigned IW = idx_bits(MAX_LEN);
  localparam int unsigned CW = cnt_bits(MAX_LEN);

  state_t        state;
  state_t        state_next;
  logic [IW-1:0] k;
  logic          accept;
  logic          compute;
  logic          empty;
  logic          row_end;
  logic          table_end;
  logic          emit_end;
  logic [CW-1:0] start_full;

  assign accept     = start && (state == ST_IDLE);
  assign compute    = accept && (action == ACT_COMPUTE);
  assign empty      = (a_count == '0) || (b_count == '0);
  assign row_end    = (CW'(col) == b_count - CW'(1));
  assign table_end  = row_end && (CW'(row) == a_count - CW'(1));
  assign emit_end   = (best_len == '0) || (CW'(k) == best_len - CW'(1));
  assign start_full = CW'(best_end) + CW'(1) - best_len;
  assign start_pos  = start_full[IW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (compute) begin
          state_next = empty ? ST_EMIT : ST_FILL;
        end
      end
      ST_FILL: begin
        if (table_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_end) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy                  = (state != ST_IDLE);
    str_ctl.append_first  = accept && (action == ACT_FIRST);
    str_ctl.append_second = accept && (action == ACT_SECOND);
    str_ctl.clear         = (state == ST_TAIL);
    cell_ctl.issue        = (state == ST_FILL);
    cell_ctl.clear_best   = compute;
    cell_ctl.first_row    = (row == '0);
    cell_ctl.first_col    = (col == '0);
    a_addr                = (state == ST_EMIT) ? start_pos + k : row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      row    <= '0;
      col    <= '0;
      k      <= '0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_EMIT);
      last   <= (state == ST_EMIT) && emit_end;
      if (state == ST_IDLE) begin
        row <= '0;
        col <= '0;
        k   <= '0;
      end
      if (state == ST_FILL) begin
        if (row_end) begin
          col <= '0;
          row <= row + IW'(1);
        end else begin
          col <= col + IW'(1);
        end
      end
      if (state == ST_EMIT) begin
        k <= k + IW'(1);
      end
    end
  end

  `LCS_ASSERT_IMPL(a_strobe_after_emit, strobe, $past(state) == ST_EMIT, "result outside emit")
  `LCS_ASSERT_NEXT(a_tail_to_idle, state == ST_TAIL, state == ST_IDLE, "tail did not end run")
  `LCS_ASSERT_NEXT(a_compute_busy, compute, busy, "compute request did not raise busy")
  `LCS_ASSERT_IMPL(a_cell_in_range, state == ST_FILL,
                   (CW'(row) < a_count) && (CW'(col) < b_count), "cell outside strings")

endmodule

### design/longest_common_substring.sv
// Top level of the longest common substring engine.
// Depends on lcs_pkg, lcs_strings, lcs_table and lcs_ctrl.
//
// A request is taken at a rising edge where start is high and busy is low.
// Action 0 appends symbol to the first string and action 1 to the second;
// each string holds up to MAX_LEN bytes, and further bytes are dropped and
// reported later through truncated. Appends are taken one per cycle while busy
// is low and never raise busy. Action 2 runs the search, and action 3 is taken
// and ignored. A search keeps busy high while it walks the m by n table,
// where m and n are the two string lengths, and while the result goes out;
// the walk is skipped when a string is empty. The table walk visits one cell
// per cycle: one read-modify-write of the suffix row memory, with the two
// string memories read in the same cycle. The substring then comes out one
// byte per cycle, each on the result ports for exactly one cycle with strobe
// high, and the receiver must take every result as it comes, since there is
// no way to stall it. The final byte carries last. When nothing matches, a
// single result with found low, all-zero payload and last high is given.
// After the run both strings are empty and the truncation flag is cleared.
module longest_common_substring #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  logic [7:0] symbol,
  output logic       busy,
  output logic       strobe,
  output logic       found,
  output logic [7:0] out_symbol,
  output logic [5:0] match_length,
  output logic [4:0] start_index,
  output logic       truncated,
  output logic       last
);
  import lcs_pkg::*;

  localparam int unsigned IW = idx_bits(MAX_LEN);
  localparam int unsigned CW = cnt_bits(MAX_LEN);

  str_ctl_t      str_ctl;
  cell_ctl_t     cell_ctl;
  logic [IW-1:0] row;
  logic [IW-1:0] col;
  logic [IW-1:0] a_addr;
  logic [IW-1:0] start_pos;
  logic [7:0]    a_data;
  logic [7:0]    b_data;
  logic [CW-1:0] a_count;
  logic [CW-1:0] b_count;
  logic [CW-1:0] best_len;
  logic [IW-1:0] best_end;
  logic          overflow;

  // The column index addresses the second string directly.
  lcs_strings #(.MAX_LEN(MAX_LEN)) u_strings (
    .clk      (clk),
    .rst      (rst),
    .ctl      (str_ctl),
    .symbol   (symbol),
    .a_addr   (a_addr),
    .b_addr   (col),
    .a_data   (a_data),
    .b_data   (b_data),
    .a_count  (a_count),
    .b_count  (b_count),
    .overflow (overflow)
  );

  lcs_table #(.MAX_LEN(MAX_LEN)) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cell_ctl),
    .row      (row),
    .col      (col),
    .a_data   (a_data),
    .b_data   (b_data),
    .best_len (best_len),
    .best_end (best_end)
  );

  lcs_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .a_count   (a_count),
    .b_count   (b_count),
    .best_len  (best_len),
    .best_end  (best_end),
    .busy      (busy),
    .str_ctl   (str_ctl),
    .cell_ctl  (cell_ctl),
    .row       (row),
    .col       (col),
    .a_addr    (a_addr),
    .start_pos (start_pos),
    .strobe    (strobe),
    .last      (last)
  );

  // The best run stays put while results go out, and the byte read for
  // each result arrives from the first string memory in the strobe cycle.
  // The strings are cleared only as the last result leaves, so truncated
  // still reports this run.
  assign found        = (best_len != '0);
  assign out_symbol   = found ? a_data : 8'd0;
  assign match_length = 6'(best_len);
  assign start_index  = found ? 5'(start_pos) : 5'd0;
  assign truncated    = overflow;

endmodule
